// File: design/dpbg_pkg.sv
// Shared types, constants and the tanh lookup table for the dot-product GeLU block.
package dpbg_pkg;

    // Accumulator limits, signed Q.24 in 48 bits.
    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    // GeLU constants in Q.30: sqrt(2/pi) and 0.044715.
    localparam logic [29:0] GELU_C1 = 30'd856722024;
    localparam logic [29:0] GELU_C2 = 30'd48012366;

    // 1.0 in the Q.15 tanh format.
    localparam logic [16:0] TANH_ONE = 17'd32768;

    // The table covers |t| < 4 with a power-of-two number of entries.
    localparam int TANH_DEPTH = 256;
    localparam int TANH_IDX_W = $clog2(TANH_DEPTH);
    localparam logic [63:0] TANH_DEN = 64'(16 * TANH_DEPTH);
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Rounding offsets for the epilogue shifts.
    localparam logic [62:0] RND_Q23 = 63'd1 << 23;
    localparam logic [62:0] RND_Q27 = 63'd1 << 27;
    localparam logic [62:0] RND_Q29 = 63'd1 << 29;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_BIAS,
        OP_SQUARE,
        OP_CUBE,
        OP_POLY,
        OP_ARG,
        OP_LOOKUP,
        OP_INTERP,
        OP_SCALE,
        OP_ROUND
    } t_dp_op;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_done;
    } t_dp_status;

    // Restoring division, used only while the table constant is elaborated.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], num[k]};
            if (r >= den) begin
                r    = r - den;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4*i/TANH_DEPTH) in Q.15: a short series at 1/64 of the argument,
    // then six applications of the double-angle identity.
    function automatic logic [15:0] tanh_entry(input logic [63:0] idx);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u5;
        logic [63:0] u7;
        logic [63:0] t;
        u  = ((idx << 30) + TANH_DEN / 2) / TANH_DEN;
        u2 = (u * u) >> 30;
        u3 = (u2 * u) >> 30;
        u5 = (u3 * u2) >> 30;
        u7 = (u5 * u2) >> 30;
        t  = u + (64'd2 * u5) / 15 - u3 / 3 - (64'd17 * u7) / 315;
        for (int k = 0; k < 6; k++) begin
            t = div_u64((64'd2 * t) << 30, ONE_Q30 + ((t * t) >> 30));
        end
        t = (t + 64'd16384) >> 15;
        return (t > 64'd32767) ? 16'd32767 : t[15:0];
    endfunction

    function automatic logic [TANH_DEPTH*16-1:0] tanh_rom_build();
        logic [TANH_DEPTH*16-1:0] rom;
        rom = '0;
        for (int i = 0; i < TANH_DEPTH; i++) begin
            rom[i*16 +: 16] = tanh_entry(64'(i));
        end
        return rom;
    endfunction

    localparam logic [TANH_DEPTH*16-1:0] TANH_ROM = tanh_rom_build();

endpackage

// File: design/dot_product_bias_gelu.sv
// Throughput: one term per cycle while s_axis_tready is high; after a last term no new
// transaction is taken until the nine-step epilogue, which shares one multiplier, has
// written its result to the output register, which waits while the output is stalled.
// A last term passes the input, product and accumulator stages, then the epilogue.
// Reset (i_rst_n low, synchronous) clears the accumulator, the overflow flag,
// the pipeline valid bits and the output valid; the tanh table is constant.
module dot_product_bias_gelu
    import dpbg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // a_value [15:0], b_value [31:16], bias_value [47:32]
    input  logic        s_axis_tlast,  // last_term
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // activation [15:0]
    output logic [0:0]  m_axis_tuser   // saturated [0]
);

    t_dp_cmd    cmd;
    t_dp_status status;

    dpbg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    dpbg_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser[0])
    );

endmodule

// File: design/dpbg_datapath.sv
// Datapath: multiply-accumulate pipeline and the shared-multiplier GeLU epilogue.
module dpbg_datapath
    import dpbg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic [47:0] i_tdata,  // a_value [15:0], b_value [31:16], bias_value [47:32]
    input  logic        i_tlast,  // last_term
    output logic [15:0] o_tdata,  // activation [15:0]
    output logic        o_tuser   // saturated [0]
);

    // Input stage.
    logic signed [15:0] r_a;
    logic signed [15:0] r_b;
    logic signed [15:0] r_bias;
    logic               r_v1;
    logic               r_last1;

    // Product stage.
    logic signed [31:0] r_mac;
    logic               r_v2;
    logic               r_last2;

    // Accumulator stage.
    logic signed [47:0] r_acc;
    logic               r_ovf;
    logic               r_acc_done;

    // Epilogue registers.
    logic signed [47:0] r_x;
    logic [26:0]        r_m;
    logic               r_neg;
    logic               r_big;
    logic               r_small;
    logic [62:0]        r_prod;
    logic [15:0]        r_lo;
    logic [15:0]        r_diff;
    logic [23:0]        r_frac;
    logic               r_tsat;

    // Result register.
    logic [15:0]        r_act;
    logic               r_sat;

    logic signed [48:0] acc_sum;
    logic signed [48:0] bias_sum;
    logic [47:0]        x_abs;
    logic               x_out_range;
    logic [62:0]        rnd23_sum;
    logic [62:0]        rnd27_sum;
    logic [62:0]        rnd29_sum;
    logic [29:0]        arg_t0;
    logic [29:0]        arg_t;
    logic [TANH_IDX_W+23:0] tab_pos;
    logic [TANH_IDX_W-1:0]  tab_idx;
    logic [TANH_IDX_W-1:0]  tab_idx_nx;
    logic [15:0]        tab_lo;
    logic [15:0]        tab_hi;
    logic [16:0]        tanh_mag;
    logic [16:0]        gelu_factor;
    logic [17:0]        out_mag;
    logic [15:0]        res_act;
    logic               res_clip;
    logic [32:0]        mul_a;
    logic [29:0]        mul_b;
    logic [62:0]        mul_p;
    logic               mul_en;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] s);
        if (s[48] != s[47]) begin
            return s[48] ? ACC_MIN : ACC_MAX;
        end
        return s[47:0];
    endfunction

    assign acc_sum  = 49'(r_acc) + 49'(r_mac);
    assign bias_sum = 49'(r_acc) + 49'($signed({r_bias, 12'd0}));

    // Magnitude of x; anything at or beyond 8.0 takes the short path.
    assign x_abs       = r_x[47] ? 48'(-r_x) : 48'(r_x);
    assign x_out_range = (x_abs[47:27] != '0);

    assign rnd23_sum = r_prod + RND_Q23;
    assign rnd27_sum = r_prod + RND_Q27;
    assign rnd29_sum = r_prod + RND_Q29;

    assign arg_t0 = 30'(r_m) + rnd29_sum[59:30];
    assign arg_t  = rnd29_sum[59:30];

    // Table position: t * depth / 4 with a 24-bit fraction.
    assign tab_pos    = {arg_t[25:0], {(TANH_IDX_W-2){1'b0}}};
    assign tab_idx    = tab_pos[24 +: TANH_IDX_W];
    assign tab_idx_nx = tab_idx + 1'b1;
    assign tab_lo     = TANH_ROM[{tab_idx, 4'b0000} +: 16];

    always_comb begin
        if (tab_idx == TANH_IDX_W'(TANH_DEPTH - 1)) begin
            tab_hi = TANH_ONE[15:0];
        end else begin
            tab_hi = TANH_ROM[{tab_idx_nx, 4'b0000} +: 16];
        end
        if (tab_hi < tab_lo) begin
            tab_hi = tab_lo;
        end
    end

    assign tanh_mag    = r_tsat ? TANH_ONE : (17'(r_lo) + rnd23_sum[40:24]);
    assign gelu_factor = r_neg ? (TANH_ONE - tanh_mag) : (TANH_ONE + tanh_mag);
    assign out_mag     = rnd27_sum[45:28];

    always_comb begin
        res_act  = '0;
        res_clip = 1'b0;
        if (r_big) begin
            res_act  = 16'h7FFF;
            res_clip = 1'b1;
        end else if (r_small) begin
            res_act = '0;
        end else if (!r_neg) begin
            if (out_mag[17:15] != '0) begin
                res_act  = 16'h7FFF;
                res_clip = 1'b1;
            end else begin
                res_act = out_mag[15:0];
            end
        end else begin
            if (out_mag > 18'd32768) begin
                res_act  = 16'h8000;
                res_clip = 1'b1;
            end else begin
                res_act = 16'(-out_mag);
            end
        end
    end

    // One multiplier serves every product of the epilogue.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (i_cmd.op)
            OP_SQUARE: begin
                mul_a = 33'(x_abs[26:0]);
                mul_b = 30'(x_abs[26:0]);
            end
            OP_CUBE: begin
                mul_a = 33'(r_prod[53:24]);
                mul_b = 30'(r_m);
            end
            OP_POLY: begin
                mul_a = r_prod[56:24];
                mul_b = GELU_C2;
            end
            OP_ARG: begin
                mul_a = 33'(arg_t0);
                mul_b = GELU_C1;
            end
            OP_INTERP: begin
                mul_a = 33'(r_diff);
                mul_b = 30'(r_frac);
            end
            OP_SCALE: begin
                mul_a = 33'(r_m);
                mul_b = 30'(gelu_factor);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = {30'd0, mul_a} * {33'd0, mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_acc_done <= 1'b0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_v1       <= i_cmd.capture;
            r_v2       <= r_v1;
            r_acc_done <= r_v2 && r_last2;
            if (r_v2) begin
                r_acc <= sat48(acc_sum);
                if (acc_sum[48] != acc_sum[47]) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.op == OP_BIAS && bias_sum[48] != bias_sum[47]) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.op == OP_ROUND) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a     <= $signed(i_tdata[15:0]);
            r_b     <= $signed(i_tdata[31:16]);
            r_bias  <= $signed(i_tdata[47:32]);
            r_last1 <= i_tlast;
        end
        r_mac   <= r_a * r_b;
        r_last2 <= r_v1 && r_last1;
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (i_cmd.op)
            OP_BIAS: begin
                r_x <= sat48(bias_sum);
            end
            OP_SQUARE: begin
                r_m     <= x_abs[26:0];
                r_neg   <= r_x[47];
                r_big   <= x_out_range && !r_x[47];
                r_small <= x_out_range && r_x[47];
            end
            OP_LOOKUP: begin
                r_tsat <= (arg_t[29:26] != '0);
                r_lo   <= tab_lo;
                r_diff <= tab_hi - tab_lo;
                r_frac <= tab_pos[23:0];
            end
            OP_ROUND: begin
                r_act <= res_act;
                r_sat <= res_clip || r_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_status.acc_done = r_acc_done;
    assign o_tdata           = r_act;
    assign o_tuser           = r_sat;

`ifndef SYNTHESIS
    a_clear_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_ROUND |=> r_acc == '0 && !r_ovf)
        else $error("accumulator not cleared after a result");

    a_mac_idle_in_epilogue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op != OP_NONE |-> !r_v1 && !r_v2)
        else $error("epilogue runs while products are still in flight");

    a_small_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_ROUND && r_small |=> r_act == '0)
        else $error("large negative argument did not give zero");
`endif

endmodule

// File: design/dpbg_ctrl.sv
// Controller state machine: input flow control, epilogue sequencing and output valid.
module dpbg_ctrl
    import dpbg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  logic       i_s_last,
    output logic       o_s_ready,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [9:0] {
        S_RUN    = 10'b00_0000_0001,
        S_DRAIN  = 10'b00_0000_0010,
        S_SQUARE = 10'b00_0000_0100,
        S_CUBE   = 10'b00_0000_1000,
        S_POLY   = 10'b00_0001_0000,
        S_ARG    = 10'b00_0010_0000,
        S_LOOKUP = 10'b00_0100_0000,
        S_INTERP = 10'b00_1000_0000,
        S_SCALE  = 10'b01_0000_0000,
        S_ROUND  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_s_ready = (r_state == S_RUN);
    assign accept    = i_s_valid && o_s_ready;
    assign out_free  = !r_out_valid || i_m_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = accept;
        o_cmd.op      = OP_NONE;
        case (r_state)
            S_RUN: begin
                if (accept && i_s_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The bias is added as soon as the last product reaches the accumulator.
                if (i_status.acc_done) begin
                    o_cmd.op = OP_BIAS;
                    n_state  = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.op = OP_SQUARE;
                n_state  = S_CUBE;
            end
            S_CUBE: begin
                o_cmd.op = OP_CUBE;
                n_state  = S_POLY;
            end
            S_POLY: begin
                o_cmd.op = OP_POLY;
                n_state  = S_ARG;
            end
            S_ARG: begin
                o_cmd.op = OP_ARG;
                n_state  = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.op = OP_LOOKUP;
                n_state  = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.op = OP_INTERP;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                if (out_free) begin
                    o_cmd.op = OP_ROUND;
                    n_state  = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_ROUND && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

`ifndef SYNTHESIS
    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_last |=> !o_s_ready)
        else $error("input still taken after the last term");

    a_result_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_ROUND))
        else $error("result valid raised outside the final epilogue step");

    a_done_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.acc_done |-> r_state == S_DRAIN)
        else $error("last product accumulated outside the drain state");

    a_round_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND && !out_free |=> r_state == S_ROUND && r_out_valid)
        else $error("result overwritten before the previous one was taken");
`endif

endmodule
